FILE: rtl/core/scrc_pkg.sv
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared constants, types and helper functions for the serial CRC block.
// ----------------------------------------------------------------------------
`default_nettype none

package scrc_pkg;

   // Largest remainder degree the datapath supports.
   localparam int MAX_DEGREE  = 32;
   localparam int REM_W       = MAX_DEGREE;
   localparam int REM_AW      = $clog2(REM_W);
   localparam int DEG_W       = $clog2(MAX_DEGREE + 1);

   // Configuration register widths.
   localparam int POLY_W      = 33;
   localparam int CRC_WIDTH_W = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = POLY_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLYNOMIAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [POLY_W-1:0]      POLY_RESET      = 33'd263;
   localparam logic [CRC_WIDTH_W-1:0] CRC_WIDTH_RESET = 6'd9;

   // Mode codes.
   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_CHECK    = 1'b1;

   // Decoupling queue between classifier and output sequencer.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   // One queued work entry: a result plus an optional remainder burst.
   typedef struct packed {
      logic             out_bit;
      logic             crc_ok;
      logic             end_of_run;
      logic             flush;
      logic [DEG_W-1:0] deg;
      logic [REM_W-1:0] rem;
   } q_entry_type;

   // Remainder degree from the width register, clamped to 0..MAX_DEGREE.
   function automatic logic [DEG_W-1:0] degree_of(input logic [CRC_WIDTH_W-1:0] w);
      logic [DEG_W-1:0] d;
      if (w < CRC_WIDTH_W'(2)) begin
         d = '0;
      end else if (w > CRC_WIDTH_W'(MAX_DEGREE + 1)) begin
         d = DEG_W'(MAX_DEGREE);
      end else begin
         d = DEG_W'(w - CRC_WIDTH_W'(1));
      end
      return d;
   endfunction

   // Low d bits set.
   function automatic logic [REM_W-1:0] mask_of(input logic [DEG_W-1:0] d);
      logic [REM_W:0] m;
      m = ({{REM_W{1'b0}}, 1'b1} << d) - {{REM_W{1'b0}}, 1'b1};
      return m[REM_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scrc_ifs.sv
// ----------------------------------------------------------------------------
// scrc_ifs
// Valid/ready channel interfaces: message bits in, result bits out, CSR writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface scrc_req_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic last_bit;

   modport source (output valid, output data_bit, output last_bit, input ready);
   modport sink   (input valid, input data_bit, input last_bit, output ready);
endinterface

interface scrc_rsp_if;
   logic valid;
   logic ready;
   logic out_bit;
   logic crc_ok;
   logic end_of_run;

   modport source (output valid, output out_bit, output crc_ok, output end_of_run,
                   input ready);
   modport sink   (input valid, input out_bit, input crc_ok, input end_of_run,
                   output ready);
endinterface

interface scrc_csr_if import scrc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/scrc_front.sv
// ----------------------------------------------------------------------------
// scrc_front
// Config registers, remainder update per accepted bit, and entry classification.
// ----------------------------------------------------------------------------
`default_nettype none

module scrc_front import scrc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   scrc_req_if.sink         req,
   scrc_csr_if.sink         csr,
   input  wire logic        q_full,
   output logic             q_push,
   output q_entry_type      q_wdata
);

   logic [POLY_W-1:0]      polynomial_ff, polynomial_in;
   logic [CRC_WIDTH_W-1:0] crc_width_ff, crc_width_in;
   logic                   mode_ff, mode_in;
   logic [REM_W-1:0]       remainder_ff, remainder_in;

   logic                   accept;
   logic [DEG_W-1:0]       deg;
   logic [DEG_W-1:0]       deg_m1;
   logic [REM_W-1:0]       mask;
   logic [REM_W-1:0]       taps;
   logic [REM_W-1:0]       rem;
   logic                   fb;
   logic [REM_W-1:0]       shifted;
   logic [REM_W-1:0]       rem_gen;
   logic [REM_W:0]         chk_t;
   logic [REM_W:0]         chk_x;
   logic [REM_W-1:0]       rem_chk;

   assign csr.ready = 1'b1;
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      polynomial_in = polynomial_ff;
      crc_width_in  = crc_width_ff;
      mode_in       = mode_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_POLYNOMIAL: polynomial_in = csr.wdata[POLY_W-1:0];
            CSR_CRC_WIDTH:  crc_width_in  = csr.wdata[CRC_WIDTH_W-1:0];
            CSR_MODE:       mode_in       = csr.wdata[0];
            default:        ;
         endcase
      end
   end

   // Remainder datapath, masked to the current degree.
   assign deg    = degree_of(crc_width_ff);
   assign deg_m1 = deg - DEG_W'(1);
   assign mask   = mask_of(deg);
   assign taps   = polynomial_ff[REM_W-1:0] & mask;
   assign rem    = remainder_ff & mask;

   // Generate: message shifted by x^D, feedback from the top remainder bit.
   // With zero degree everything masks to zero.
   assign fb      = rem[deg_m1[REM_AW-1:0]] ^ req.data_bit;
   assign shifted = {rem[REM_W-2:0], 1'b0} & mask;
   assign rem_gen = fb ? (shifted ^ taps) : shifted;

   // Check: plain division of the received word.
   assign chk_t   = {rem, req.data_bit};
   assign chk_x   = chk_t[deg] ? (chk_t ^ {1'b0, taps}) : chk_t;
   assign rem_chk = chk_x[REM_W-1:0] & mask;

   always_comb begin
      remainder_in = remainder_ff;
      if (accept) begin
         if (req.last_bit) begin
            remainder_in = '0;
         end else if (mode_ff == MODE_CHECK) begin
            remainder_in = rem_chk;
         end else begin
            remainder_in = rem_gen;
         end
      end
   end

   always_comb begin
      q_push = accept && ((mode_ff == MODE_GENERATE) || req.last_bit);
      if (mode_ff == MODE_GENERATE) begin
         q_wdata.out_bit    = req.data_bit;
         q_wdata.crc_ok     = 1'b0;
         q_wdata.end_of_run = req.last_bit && (deg == '0);
         q_wdata.flush      = req.last_bit && (deg != '0);
         q_wdata.deg        = deg;
         q_wdata.rem        = rem_gen;
      end else begin
         q_wdata.out_bit    = 1'b0;
         q_wdata.crc_ok     = (rem_chk == '0);
         q_wdata.end_of_run = 1'b1;
         q_wdata.flush      = 1'b0;
         q_wdata.deg        = deg;
         q_wdata.rem        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff <= POLY_RESET;
         crc_width_ff  <= CRC_WIDTH_RESET;
         mode_ff       <= MODE_GENERATE;
         remainder_ff  <= '0;
      end else begin
         polynomial_ff <= polynomial_in;
         crc_width_ff  <= crc_width_in;
         mode_ff       <= mode_in;
         remainder_ff  <= remainder_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/scrc_queue.sv
// ----------------------------------------------------------------------------
// scrc_queue
// Short FIFO of work entries between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module scrc_queue import scrc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  q_entry_type      wdata,
   input  wire logic        pop,
   output logic             full,
   output logic             empty,
   output q_entry_type      head
);

   q_entry_type            mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]        count_ff, count_in;

   assign full  = (count_ff == Q_CW'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/scrc_back.sv
// ----------------------------------------------------------------------------
// scrc_back
// Output sequencer: drains queued entries and bursts out remainder bits.
// ----------------------------------------------------------------------------
`default_nettype none

module scrc_back import scrc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  q_entry_type      q_head,
   output logic             q_pop,
   scrc_rsp_if.source       rsp
);

   logic                   out_valid_ff, out_valid_in;
   logic                   out_bit_ff, out_bit_in;
   logic                   crc_ok_ff, crc_ok_in;
   logic                   end_ff, end_in;
   logic [DEG_W-1:0]       flush_cnt_ff, flush_cnt_in;
   logic [REM_W-1:0]       rem_ff, rem_in;

   logic                   out_free;
   logic [DEG_W-1:0]       fidx_full;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign fidx_full = flush_cnt_ff - DEG_W'(1);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_bit_in   = out_bit_ff;
      crc_ok_in    = crc_ok_ff;
      end_in       = end_ff;
      flush_cnt_in = flush_cnt_ff;
      rem_in       = rem_ff;
      q_pop        = 1'b0;
      if (out_free) begin
         if (flush_cnt_ff != '0) begin
            // remainder burst, MSB first
            out_valid_in = 1'b1;
            out_bit_in   = rem_ff[fidx_full[REM_AW-1:0]];
            crc_ok_in    = 1'b0;
            end_in       = (flush_cnt_ff == DEG_W'(1));
            flush_cnt_in = fidx_full;
         end else if (!q_empty) begin
            q_pop        = 1'b1;
            out_valid_in = 1'b1;
            out_bit_in   = q_head.out_bit;
            crc_ok_in    = q_head.crc_ok;
            end_in       = q_head.end_of_run;
            if (q_head.flush) begin
               flush_cnt_in = q_head.deg;
               rem_in       = q_head.rem;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_bit    = out_bit_ff;
   assign rsp.crc_ok     = crc_ok_ff;
   assign rsp.end_of_run = end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         flush_cnt_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         flush_cnt_ff <= flush_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_bit_ff <= out_bit_in;
      crc_ok_ff  <= crc_ok_in;
      end_ff     <= end_in;
      rem_ff     <= rem_in;
   end

`ifndef SYNTH
   a_burst_has_output: assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff != '0) |-> out_valid_ff)
      else $error("remainder burst pending without a valid result");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      flush_cnt_ff <= DEG_W'(MAX_DEGREE))
      else $error("burst count above maximum degree");

   a_burst_ends_run: assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff == DEG_W'(1) && out_free) |=>
      (out_valid_ff && end_ff && flush_cnt_ff == '0))
      else $error("last remainder bit not marked end of run");

   a_no_pop_in_burst: assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff != '0) |-> !q_pop)
      else $error("queue popped during remainder burst");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/serial_crc_generate_and_check.sv
// Check mode gives one result per message, on its last bit. Results pass through the
//   queue into the output register. Throughput: one bit transaction per cycle unless the
//   queue is full; a generate-mode last bit adds D = width-1 (clamped to 0..32)
//   remainder transactions on the output, absorbed by a 4-entry queue before req stalls.
// Reset (synchronous, active high): config to polynomial 263, width 9, generate mode;
//   remainder, queue and output valid cleared.
// ----------------------------------------------------------------------------
// serial_crc_generate_and_check
// Bit-serial CRC generator/checker with programmable polynomial and width.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_crc_generate_and_check import scrc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   scrc_req_if.sink         req_bus,
   scrc_rsp_if.source       rsp_bus,
   scrc_csr_if.sink         csr_bus
);

   // Front -> queue
   logic        q_push;
   q_entry_type q_wdata;
   logic        q_full;

   // Queue -> back
   logic        q_pop;
   logic        q_empty;
   q_entry_type q_head;

   // Front: holds config, divides each accepted bit into the remainder and
   // turns the transaction into a queue entry. Check mode only queues on the
   // last bit; a generate-mode last bit carries the final remainder along.
   scrc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .csr     (csr_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_wdata (q_wdata)
   );

   // Queue decouples input acceptance from the output burst.
   scrc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (q_head)
   );

   // Back: one result per cycle into the output register unless stalled, expanding
   // a flush entry into its remainder bits, MSB first, last one flagged end of run.
   scrc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_serial_crc_generate_and_check.sv
// ----------------------------------------------------------------------------
// tb_serial_crc_generate_and_check
// Self-checking bench for the bit-serial CRC generator/checker. A bit-accurate
// predictor tracks the remainder under the current polynomial, width and mode.
// It queues the expected results as message bits are accepted. A short
// directed pass hits width clamping, the all-ones and CRC-32 polynomials, check
// mode on good words and config changes mid-message. Random phases follow,
// with random config, well-formed and corrupted codewords and random
// backpressure on the result side and random gaps on the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_serial_crc_generate_and_check import scrc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   typedef bit bit_list_type[$];

   // One expected transaction on the result channel.
   typedef struct packed {
      logic out_bit;
      logic crc_ok;
      logic end_of_run;
   } crc_result_type;

   // Remainder tracker: mirrors the config registers, predicts the output bits
   // and holds them until the block delivers them.
   class crc_bit_tracker;
      logic [POLY_W-1:0]      poly;
      logic [CRC_WIDTH_W-1:0] width;
      logic                   mode;
      logic [REM_W-1:0]       rem;
      crc_result_type         due[$];
      int                     errors;

      function new();
         poly   = POLY_RESET;
         width  = CRC_WIDTH_RESET;
         mode   = MODE_GENERATE;
         rem    = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_POLYNOMIAL: poly = value[POLY_W-1:0];
            CSR_CRC_WIDTH:  width = value[CRC_WIDTH_W-1:0];
            CSR_MODE:       mode = value[0];
            default: ;
         endcase
      endfunction

      // width - 1, clamped to 0..MAX_DEGREE
      function int unsigned rem_degree();
         int unsigned w;
         w = width;
         if (w < 2) return 0;
         if (w - 1 > MAX_DEGREE) return MAX_DEGREE;
         return w - 1;
      endfunction

      function logic [REM_W-1:0] low_mask(int unsigned d);
         return (d == 0) ? '0 : ({REM_W{1'b1}} >> (REM_W - d));
      endfunction

      // One step of the generator LFSR (message * x^D mod P).
      function logic [REM_W-1:0] feed_generate(logic [REM_W-1:0] r, logic b);
         int unsigned      d;
         logic [REM_W-1:0] mask;
         logic             fb;
         d = rem_degree();
         if (d == 0) return '0;
         mask = low_mask(d);
         fb   = r[d-1] ^ b;
         r    = (r << 1) & mask;
         if (fb) r ^= poly[REM_W-1:0] & mask;
         return r;
      endfunction

      function logic [REM_W-1:0] checksum_of(bit_list_type msg);
         logic [REM_W-1:0] r;
         r = '0;
         foreach (msg[i]) r = feed_generate(r, msg[i]);
         return r;
      endfunction

      function void take_bit(logic b, logic last);
         int unsigned      d;
         logic [REM_W-1:0] mask;
         logic [REM_W-1:0] r;
         logic [REM_W:0]   t;
         d    = rem_degree();
         mask = low_mask(d);
         r    = rem & mask;
         if (mode == MODE_GENERATE) begin
            r = feed_generate(r, b);
            due.insert(due.size(),
                       crc_result_type'{out_bit: b, crc_ok: 1'b0,
                                        end_of_run: last && d == 0});
            if (last) begin
               for (int k = int'(d) - 1; k >= 0; k--)
                  due.insert(due.size(),
                             crc_result_type'{out_bit: r[k], crc_ok: 1'b0,
                                              end_of_run: k == 0});
               r = '0;
            end
         end else begin
            t = {r, b};
            if (t[d]) t ^= {1'b0, poly[REM_W-1:0] & mask};
            r = t[REM_W-1:0] & mask;
            if (last) begin
               due.insert(due.size(),
                          crc_result_type'{out_bit: 1'b0, crc_ok: r == '0,
                                           end_of_run: 1'b1});
               r = '0;
            end
         end
         rem = r;
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task match_output(logic o, logic ok, logic eor);
         crc_result_type want;
         if (due.size() == 0) begin
            report_mismatch($sformatf("unexpected result out=%0b ok=%0b end=%0b", o, ok, eor));
            return;
         end
         want = due.pop_front();
         if (o !== want.out_bit)
            report_mismatch($sformatf("out_bit got %0b want %0b", o, want.out_bit));
         if (ok !== want.crc_ok)
            report_mismatch($sformatf("crc_ok got %0b want %0b", ok, want.crc_ok));
         if (eor !== want.end_of_run)
            report_mismatch($sformatf("end_of_run got %0b want %0b", eor, want.end_of_run));
      endtask
   endclass

   logic clock;
   logic reset;

   scrc_req_if req_bus ();
   scrc_rsp_if rsp_bus ();
   scrc_csr_if csr_bus ();

   serial_crc_generate_and_check dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   crc_bit_tracker tracker = new();

   // Phase-wide switches that turn idling off on one side for a stretch.
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int bits_sent  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #100ms;
      $display("status: fail");
      $finish;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int idle_length(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // --- result side --------------------------------------------------------
   // Ready is raised, then dropped for a random stall (often none).
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall_left = idle_length(rsp_steady);
         end
      end
   end

   // Sample at the rising edge; values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready)
         tracker.match_output(rsp_bus.out_bit, rsp_bus.crc_ok, rsp_bus.end_of_run);
   end

   // --- input side ---------------------------------------------------------
   // All driver tasks start and end on a falling edge.
   task automatic send_bit(input logic b, input logic last);
      int gap;
      gap = idle_length(req_steady);
      repeat (gap) @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.data_bit = b;
      req_bus.last_bit = last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.take_bit(b, last);
      bits_sent++;
      @(negedge clock);
      // junk payload while valid is low
      req_bus.valid    = 1'b0;
      req_bus.data_bit = 1'($urandom_range(0, 1));
      req_bus.last_bit = 1'($urandom_range(0, 1));
   endtask

   task automatic send_word(input bit_list_type word);
      foreach (word[i]) send_bit(word[i], i == word.size() - 1);
   endtask

   // Hold the sender until every predicted result is back, then let the
   // pipeline empty out so a bit with no result is done too.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (tracker.due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Config writes only ever happen with the block idle.
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.write_reg(idx, value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Message followed by its remainder under the current config: a good word.
   function automatic bit_list_type with_checksum(bit_list_type msg);
      bit_list_type     word;
      logic [REM_W-1:0] sum;
      int               d;
      word = msg;
      sum  = tracker.checksum_of(msg);
      d    = tracker.rem_degree();
      for (int k = d - 1; k >= 0; k--) word.insert(word.size(), sum[k]);
      return word;
   endfunction

   // --- stimulus -----------------------------------------------------------
   initial begin
      bit_list_type           msg;
      logic [CSR_DATA_W-1:0]  p;
      logic [CRC_WIDTH_W-1:0] w;
      int                     base;
      int                     len;
      int                     pos;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.data_bit = 1'b0;
      req_bus.last_bit = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_POLYNOMIAL;
      csr_bus.wdata    = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Reset config: 9-bit polynomial, generate mode, 8 appended bits.
      send_word('{1'b1, 1'b0, 1'b1});

      // Width 0: nothing appended, end_of_run rides on the data bit.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(0));
      send_word('{1'b1});
      send_word('{1'b0});

      // Width 63 clamps to degree 32; all polynomial bits set.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(63));
      set_reg(CSR_POLYNOMIAL, {CSR_DATA_W{1'b1}});
      send_word('{1'b1, 1'b1});

      // Full 33-bit polynomial, single-bit message.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(33));
      set_reg(CSR_POLYNOMIAL, 33'h1_04C1_1DB7);
      send_word('{1'b1});

      // Check mode on a good codeword: crc_ok expected high.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(9));
      set_reg(CSR_POLYNOMIAL, POLY_RESET);
      set_reg(CSR_MODE, CSR_DATA_W'(MODE_CHECK));
      send_word(with_checksum('{1'b1, 1'b0, 1'b1}));

      // Width 1 in check mode: always reports ok.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(1));
      send_word('{1'b1});

      // Width and polynomial change in the middle of a word; the high
      // polynomial bits must be ignored.
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(9));
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(5));
      set_reg(CSR_POLYNOMIAL, 33'h1_0000_0013);
      send_bit(1'b0, 1'b1);

      // Mode flip mid-message keeps the remainder.
      set_reg(CSR_MODE, CSR_DATA_W'(MODE_GENERATE));
      send_bit(1'b1, 1'b0);
      set_reg(CSR_MODE, CSR_DATA_W'(MODE_CHECK));
      send_bit(1'b0, 1'b1);

      // Random phases: fresh config each phase, then a few messages.
      base = bits_sent;
      while (bits_sent - base < 380) begin
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);

         // mostly small widths to keep bursts and codewords short
         case ($urandom_range(0, 7))
            0:       w = CRC_WIDTH_W'($urandom_range(0, 1));
            1:       w = CRC_WIDTH_W'(33);
            2:       w = CRC_WIDTH_W'($urandom_range(34, 63));
            3:       w = CRC_WIDTH_W'($urandom_range(14, 32));
            default: w = CRC_WIDTH_W'($urandom_range(2, 13));
         endcase
         case ($urandom_range(0, 5))
            0:       p = {CSR_DATA_W{1'b1}};
            1:       p = CSR_DATA_W'(1);
            default: begin
               p[32]   = 1'($urandom_range(0, 1));
               p[31:0] = $urandom();
            end
         endcase
         set_reg(CSR_CRC_WIDTH, CSR_DATA_W'(w));
         set_reg(CSR_POLYNOMIAL, p);
         set_reg(CSR_MODE, CSR_DATA_W'($urandom_range(0, 1)));

         repeat ($urandom_range(2, 6)) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            msg.delete();
            repeat (len) msg.insert(msg.size(), 1'($urandom_range(0, 1)));
            // check mode: mostly good words, some with one bit flipped, rest noise
            if (tracker.mode == MODE_CHECK && $urandom_range(0, 3) != 0) begin
               msg = with_checksum(msg);
               if ($urandom_range(0, 3) == 0) begin
                  pos      = $urandom_range(0, msg.size() - 1);
                  msg[pos] = !msg[pos];
               end
            end
            send_word(msg);
            // occasional full drain between messages
            if ($urandom_range(0, 9) == 0) settle();
         end
      end

      // Drain with a bound so a lost result is reported rather than hung on.
      req_bus.valid = 1'b0;
      for (int k = 0; k < 20000 && tracker.due.size() != 0; k++) @(negedge clock);
      repeat (20) @(negedge clock);
      if (tracker.due.size() != 0)
         tracker.report_mismatch($sformatf("%0d results never arrived", tracker.due.size()));

      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
